// File: hw/rtl/urf_pkg.sv
// shared constants, types and codes for the serial receiver with receive fifo
package urf_pkg;

   // receive fifo geometry
   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int FILL_W = IDX_W + 1;

   // word field widths
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 6;

   // configuration registers
   localparam int PERIOD_W    = 16;
   localparam int BITS_W      = 4;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET   = PERIOD_W'(16);
   localparam logic [BITS_W-1:0]   NUM_BITS_RESET = BITS_W'(8);
   localparam logic [BITS_W-1:0]   NUM_BITS_MIN   = BITS_W'(1);
   localparam logic [BITS_W-1:0]   NUM_BITS_MAX   = BITS_W'(BYTE_W);

   localparam logic [CSR_IDX_W-1:0] CSR_BIT_PERIOD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BITS   = CSR_IDX_W'(1);

   // receiver phases
   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_CENTER = 4'b0010,
      PH_DATA   = 4'b0100,
      PH_STOP   = 4'b1000
   } rx_phase_type;

   // byte handed from receiver to fifo
   typedef struct packed {
      logic              en;
      logic [BYTE_W-1:0] data;
   } push_type;

   // result fields apart from the popped byte
   typedef struct packed {
      logic               read_valid;
      logic [COUNT_W-1:0] fifo_count;
      logic               overrun_seen;
      logic               receiving;
   } result_type;

endpackage

// File: hw/rtl/urf_rx.sv
// serial frame receiver: start edge, centring wait, lsb-first sampling
module urf_rx
   import urf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                rx_level,
   input  logic [PERIOD_W-1:0] bit_period,
   input  logic [BITS_W-1:0]   num_bits,
   output push_type            push,
   output logic                receiving
);

   rx_phase_type        phase_ff, phase_in;
   logic                prev_level_ff;
   logic [PERIOD_W-1:0] cycle_count_ff, cycle_count_in;
   logic [BITS_W-1:0]   bits_left_ff, bits_left_in;
   logic [BYTE_W-1:0]   shift_byte_ff, shift_byte_in;

   logic [PERIOD_W-1:0] wait_len;
   logic [PERIOD_W-1:0] count_inc;
   logic                wait_done;
   logic [BITS_W-1:0]   eff_bits;
   logic [BITS_W-1:0]   align_shift;

   always_comb begin
      priority if (num_bits == '0) begin
         eff_bits = NUM_BITS_MIN;
      end else if (num_bits > NUM_BITS_MAX) begin
         eff_bits = NUM_BITS_MAX;
      end else begin
         eff_bits = num_bits;
      end
   end

   // half a bit while centring, a whole bit otherwise
   assign wait_len    = (phase_ff == PH_CENTER) ? (bit_period >> 1) : bit_period;
   assign count_inc   = cycle_count_ff + PERIOD_W'(1);
   assign wait_done   = (count_inc >= wait_len);
   assign align_shift = NUM_BITS_MAX - eff_bits;

   always_comb begin
      phase_in       = phase_ff;
      cycle_count_in = cycle_count_ff;
      bits_left_in   = bits_left_ff;
      shift_byte_in  = shift_byte_ff;
      push.en        = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (prev_level_ff && !rx_level) begin
               phase_in       = PH_CENTER;
               cycle_count_in = '0;
               bits_left_in   = eff_bits;
               shift_byte_in  = '0;
            end
         end
         PH_CENTER: begin
            cycle_count_in = wait_done ? '0 : count_inc;
            if (wait_done) begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            cycle_count_in = wait_done ? '0 : count_inc;
            if (wait_done) begin
               shift_byte_in = {rx_level, shift_byte_ff[BYTE_W-1:1]};
               bits_left_in  = bits_left_ff - BITS_W'(1);
               if (bits_left_in == '0) begin
                  push.en  = 1'b1;
                  phase_in = PH_STOP;
               end
            end
         end
         PH_STOP: begin
            cycle_count_in = wait_done ? '0 : count_inc;
            if (wait_done) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      // right-align the byte for short frames
      push.data = shift_byte_in >> align_shift;
   end

   assign receiving = (phase_in != PH_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         prev_level_ff  <= 1'b1;
         cycle_count_ff <= '0;
         bits_left_ff   <= '0;
         shift_byte_ff  <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         prev_level_ff  <= rx_level;
         cycle_count_ff <= cycle_count_in;
         bits_left_ff   <= bits_left_in;
         shift_byte_ff  <= shift_byte_in;
      end
   end

endmodule

// File: hw/rtl/urf_fifo.sv
// receive ring fifo with registered read port and sticky overrun flag
module urf_fifo
   import urf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               pop_request,
   input  logic               clear_overrun,
   input  push_type           push,
   output logic               read_valid,
   output logic [BYTE_W-1:0]  rd_data,
   output logic [COUNT_W-1:0] fifo_count,
   output logic               overrun_seen
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]  wr_next;
   logic              overrun_ff, overrun_in;
   logic              push_ok;
   logic              overflow;
   logic [FILL_W-1:0] fill;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   // pop is served before the receiver pushes in the same tick
   assign read_valid = pop_request && (rd_idx_ff != wr_idx_ff);
   assign rd_idx_in  = read_valid ? idx_inc(rd_idx_ff) : rd_idx_ff;
   assign wr_next    = idx_inc(wr_idx_ff);
   assign push_ok    = push.en && (wr_next != rd_idx_in);
   assign overflow   = push.en && !push_ok;
   assign wr_idx_in  = push_ok ? wr_next : wr_idx_ff;

   // clear first, so an overrun in the same tick still sticks
   assign overrun_in   = (overrun_ff && !clear_overrun) || overflow;
   assign overrun_seen = overrun_ff;

   assign fill = (wr_idx_in >= rd_idx_in)
      ? FILL_W'(wr_idx_in) - FILL_W'(rd_idx_in)
      : FILL_W'(wr_idx_in) + FILL_W'(DEPTH) - FILL_W'(rd_idx_in);
   assign fifo_count = COUNT_W'(fill);
   assign rd_data    = rd_data_ff;

   always_ff @(posedge clock) begin
      if (step && push_ok) begin
         mem[wr_idx_ff] <= push.data;
      end
      if (step) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff  <= '0;
         wr_idx_ff  <= '0;
         overrun_ff <= 1'b0;
      end else if (step) begin
         rd_idx_ff  <= rd_idx_in;
         wr_idx_ff  <= wr_idx_in;
         overrun_ff <= overrun_in;
      end
   end

endmodule

// File: hw/rtl/urf_out.sv
// result stage plus output register, so a new word is taken while one waits
module urf_out
   import urf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  result_type         res_in,
   input  logic [BYTE_W-1:0]  rd_data,
   input  logic               rsp_stall,
   output logic               up_stall,
   output logic               rsp_valid,
   output result_type         rsp_res,
   output logic [BYTE_W-1:0]  rsp_read_data
);

   logic              res_valid_ff, res_valid_in;
   result_type        res_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff;
   logic [BYTE_W-1:0] out_data_ff;
   logic              res_move;

   assign res_move     = res_valid_ff && (!out_valid_ff || !rsp_stall);
   assign res_valid_in = step || (res_valid_ff && !res_move);
   assign out_valid_in = res_move || (out_valid_ff && rsp_stall);
   assign up_stall     = res_valid_ff && !res_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         res_ff <= res_in;
      end
      if (res_move) begin
         out_ff      <= res_ff;
         out_data_ff <= res_ff.read_valid ? rd_data : '0;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_res       = out_ff;
   assign rsp_read_data = out_data_ff;

endmodule

// File: hw/rtl/uart_receiver_with_fifo.sv
// an accepted word is held in the result register, then in the output register that drives the result word
// throughput: one word per cycle while req_stall stays low, set by the receiver step and fifo port
// two result words can wait inside; with both held, rsp_stall stalls req in the same cycle
// reset (synchronous, active high): line idle, receiver armed, fifo empty, overrun clear,
// bit_period 16 and eight data bits; fifo contents are left as they are
module uart_receiver_with_fifo
   import urf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input words, one per receive-line tick
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_rx_level,
   input  logic                  req_pop_request,
   input  logic                  req_clear_overrun,
   // result words
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_read_valid,
   output logic [BYTE_W-1:0]     rsp_read_data,
   output logic [COUNT_W-1:0]    rsp_fifo_count,
   output logic                  rsp_overrun_seen,
   output logic                  rsp_receiving,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic                step;
   logic [PERIOD_W-1:0] bit_period_ff;
   logic [BITS_W-1:0]   num_bits_ff;
   push_type            push;
   logic                receiving;
   logic                read_valid;
   logic [BYTE_W-1:0]   rd_data;
   logic [COUNT_W-1:0]  fifo_count;
   logic                overrun_seen;
   result_type          res_in;
   result_type          rsp_res;

   // a word is taken whenever the result stage has room
   assign step = req_valid && !req_stall;

   // configuration writes are always taken; unknown indexes fall through
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= PERIOD_RESET;
         num_bits_ff   <= NUM_BITS_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_BIT_PERIOD) begin
            bit_period_ff <= csr_data[PERIOD_W-1:0];
         end
         if (csr_index == CSR_NUM_BITS) begin
            num_bits_ff <= csr_data[BITS_W-1:0];
         end
      end
   end

   // receiver: edge detect, centring, sampling and stop wait
   urf_rx u_rx (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_level   (req_rx_level),
      .bit_period (bit_period_ff),
      .num_bits   (num_bits_ff),
      .push       (push),
      .receiving  (receiving)
   );

   // ring fifo; pop is served before the push of the same tick
   urf_fifo u_fifo (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .pop_request   (req_pop_request),
      .clear_overrun (req_clear_overrun),
      .push          (push),
      .read_valid    (read_valid),
      .rd_data       (rd_data),
      .fifo_count    (fifo_count),
      .overrun_seen  (overrun_seen)
   );

   always_comb begin
      res_in.read_valid   = read_valid;
      res_in.fifo_count   = fifo_count;
      res_in.overrun_seen = overrun_seen;
      res_in.receiving    = receiving;
   end

   // result register and output register; popped byte joins from the fifo read port
   urf_out u_out (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .res_in        (res_in),
      .rd_data       (rd_data),
      .rsp_stall     (rsp_stall),
      .up_stall      (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_res       (rsp_res),
      .rsp_read_data (rsp_read_data)
   );

   assign rsp_read_valid   = rsp_res.read_valid;
   assign rsp_fifo_count   = rsp_res.fifo_count;
   assign rsp_overrun_seen = rsp_res.overrun_seen;
   assign rsp_receiving    = rsp_res.receiving;

endmodule

// File: hw/rtl/urf_checker.sv
// port-level checks for the serial receiver, bound to the top level
module urf_checker
   import urf_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_read_valid,
   input logic [BYTE_W-1:0]  rsp_read_data,
   input logic [COUNT_W-1:0] rsp_fifo_count,
   input logic               rsp_overrun_seen,
   input logic               rsp_receiving
);

   // a held result word keeps its fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_read_valid) && $stable(rsp_fifo_count)
         && $stable(rsp_overrun_seen) && $stable(rsp_receiving))
      else $error("result word changed while stalled");

   // no byte shows without a pop that hit data
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_valid |-> rsp_read_data == '0)
      else $error("read data not zero without a served pop");

   // reset empties the output side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

endmodule

bind uart_receiver_with_fifo urf_checker u_urf_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_read_valid   (rsp_read_valid),
   .rsp_read_data    (rsp_read_data),
   .rsp_fifo_count   (rsp_fifo_count),
   .rsp_overrun_seen (rsp_overrun_seen),
   .rsp_receiving    (rsp_receiving)
);
